FILE: sv/clebuf_pkg.sv
// ----------------------------------------------------------------------------
// clebuf_pkg
// Shared codes and types of the gap buffer line editor: request codes,
// status codes and the result bundle passed to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package clebuf_pkg;

	// request codes carried in req_type
	typedef enum logic [2:0] {
		REQ_INSERT    = 3'd0,
		REQ_LEFT      = 3'd1,
		REQ_RIGHT     = 3'd2,
		REQ_BACKSPACE = 3'd3,
		REQ_READ      = 3'd4
	} req_t;

	// status codes returned with every item
	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_BOUNDARY = 2'd1,
		ST_FULL     = 2'd2,
		ST_BEYOND   = 2'd3
	} status_t;

	localparam int CHAR_W  = 8;
	localparam int INDEX_W = 10;
	localparam int COUNT_W = 11;

	// one result item
	typedef struct packed {
		logic [CHAR_W-1:0]  char_out;
		logic [COUNT_W-1:0] text_length;
		logic [COUNT_W-1:0] cursor_pos;
		status_t            status;
	} result_t;

endpackage

`default_nettype wire

FILE: sv/clebuf_ram.sv
// ----------------------------------------------------------------------------
// clebuf_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// Read data holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module clebuf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/clebuf_ctrl.sv
// ----------------------------------------------------------------------------
// clebuf_ctrl
// Request sequencer of the gap buffer: holds the left and right counts,
// reads the store when an item is taken and writes back when its result is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module clebuf_ctrl #(
	parameter int STORE_DEPTH = 1024
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// request side
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [2:0]                           req_type,
	input  wire logic [clebuf_pkg::CHAR_W-1:0]        char_in,
	input  wire logic [clebuf_pkg::INDEX_W-1:0]       read_index,
	// result side
	output logic                                      res_valid,
	input  wire logic                                 res_ready,
	output clebuf_pkg::result_t                       res,
	// store port
	output logic                                      ram_we,
	output logic [$clog2(STORE_DEPTH)-1:0]            ram_waddr,
	output logic [clebuf_pkg::CHAR_W-1:0]             ram_wdata,
	output logic                                      ram_re,
	output logic [$clog2(STORE_DEPTH)-1:0]            ram_raddr,
	input  wire logic [clebuf_pkg::CHAR_W-1:0]        ram_rdata
);

	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
	localparam int A_W    = ((CNT_W > clebuf_pkg::INDEX_W) ? CNT_W : clebuf_pkg::INDEX_W) + 1;
	localparam logic [A_W-1:0] DEPTH_A = A_W'(STORE_DEPTH);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t                             state_q;
	logic [CNT_W-1:0]                   left_q;
	logic [CNT_W-1:0]                   right_q;
	logic [2:0]                         req_s1;
	logic [clebuf_pkg::CHAR_W-1:0]      char_s1;
	logic [clebuf_pkg::INDEX_W-1:0]     idx_s1;

	logic [A_W-1:0]   left_a;
	logic [A_W-1:0]   right_a;
	logic [A_W-1:0]   len_a;
	logic [A_W-1:0]   idx_a;
	logic [A_W-1:0]   idx_s1_a;
	logic [A_W-1:0]   rd_a;
	logic [A_W-1:0]   wr_a;
	logic [A_W-1:0]   len_n_a;
	logic [CNT_W-1:0] left_n;
	logic [CNT_W-1:0] right_n;
	logic             wr_en;
	logic             take;
	logic             fire;
	clebuf_pkg::status_t st;
	logic [clebuf_pkg::CHAR_W-1:0] ch;

	assign left_a   = A_W'(left_q);
	assign right_a  = A_W'(right_q);
	assign len_a    = left_a + right_a;
	assign idx_a    = A_W'(read_index);
	assign idx_s1_a = A_W'(idx_s1);

	assign in_stall  = (state_q != S_IDLE);
	assign take      = in_valid && (state_q == S_IDLE);
	assign res_valid = (state_q == S_EXEC);
	assign fire      = (state_q == S_EXEC) && res_ready;

	// read address of the item being taken
	always_comb begin
		case (req_type)
			clebuf_pkg::REQ_LEFT:  rd_a = left_a - A_W'(1);
			clebuf_pkg::REQ_RIGHT: rd_a = DEPTH_A - right_a;
			clebuf_pkg::REQ_READ:  rd_a = (idx_a < left_a) ? idx_a : DEPTH_A - len_a + idx_a;
			default:               rd_a = '0;
		endcase
	end

	assign ram_re    = take;
	assign ram_raddr = ADDR_W'(rd_a);

	// write-back and result of the item in flight
	always_comb begin
		left_n  = left_q;
		right_n = right_q;
		st      = clebuf_pkg::ST_DONE;
		wr_en   = 1'b0;
		wr_a    = left_a;
		ram_wdata = ram_rdata;
		ch      = '0;
		case (req_s1)
			clebuf_pkg::REQ_INSERT: begin
				if (len_a >= DEPTH_A) begin
					st = clebuf_pkg::ST_FULL;
				end else begin
					wr_en     = 1'b1;
					ram_wdata = char_s1;
					left_n    = left_q + CNT_W'(1);
				end
			end
			clebuf_pkg::REQ_LEFT: begin
				if (left_q == '0) begin
					st = clebuf_pkg::ST_BOUNDARY;
				end else begin
					wr_en   = 1'b1;
					wr_a    = DEPTH_A - right_a - A_W'(1);
					left_n  = left_q - CNT_W'(1);
					right_n = right_q + CNT_W'(1);
				end
			end
			clebuf_pkg::REQ_RIGHT: begin
				if (right_q == '0) begin
					st = clebuf_pkg::ST_BOUNDARY;
				end else begin
					wr_en   = 1'b1;
					left_n  = left_q + CNT_W'(1);
					right_n = right_q - CNT_W'(1);
				end
			end
			clebuf_pkg::REQ_BACKSPACE: begin
				if (left_q == '0) begin
					st = clebuf_pkg::ST_BOUNDARY;
				end else begin
					left_n = left_q - CNT_W'(1);
				end
			end
			clebuf_pkg::REQ_READ: begin
				if (idx_s1_a >= len_a) begin
					st = clebuf_pkg::ST_BEYOND;
				end else begin
					ch = ram_rdata;
				end
			end
			default: st = clebuf_pkg::ST_BOUNDARY;
		endcase
	end

	assign ram_we    = fire && wr_en;
	assign ram_waddr = ADDR_W'(wr_a);
	assign len_n_a   = A_W'(left_n) + A_W'(right_n);

	assign res.char_out    = ch;
	assign res.text_length = clebuf_pkg::COUNT_W'(len_n_a);
	assign res.cursor_pos  = clebuf_pkg::COUNT_W'(left_n);
	assign res.status      = st;

	// sequencer state, counts and captured item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			left_q  <= '0;
			right_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (res_ready) begin
						state_q <= S_IDLE;
						left_q  <= left_n;
						right_q <= right_n;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item fields, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			req_s1  <= req_type;
			char_s1 <= char_in;
			idx_s1  <= read_index;
		end
	end

endmodule

`default_nettype wire

FILE: sv/clebuf_out.sv
// ----------------------------------------------------------------------------
// clebuf_out
// Output register of the line editor: holds one result item until the
// downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module clebuf_out (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           res_valid,
	output logic                                res_ready,
	input  wire clebuf_pkg::result_t            res,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [clebuf_pkg::CHAR_W-1:0]       char_out,
	output logic [clebuf_pkg::COUNT_W-1:0]      text_length,
	output logic [clebuf_pkg::COUNT_W-1:0]      cursor_pos,
	output logic [1:0]                          status
);

	logic                valid_q;
	clebuf_pkg::result_t data_q;

	assign res_ready = !valid_q || !out_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			data_q <= res;
		end
	end

	assign out_valid   = valid_q;
	assign char_out    = data_q.char_out;
	assign text_length = data_q.text_length;
	assign cursor_pos  = data_q.cursor_pos;
	assign status      = data_q.status;

endmodule

`default_nettype wire

FILE: sv/cursor_line_editor_buffer.sv
// ----------------------------------------------------------------------------
// cursor_line_editor_buffer
// Line editor with a cursor, kept as a gap buffer in one synchronous store.
// ----------------------------------------------------------------------------
// Each item is an insert, cursor left, cursor right, backspace or indexed
// read, and returns exactly one result item with the character read, the
// text length, the cursor position and a status. Each item first reads the
// store at the address the request needs, then writes the byte back across
// the gap (or the inserted byte) and registers the result. A new item is not
// taken until the result of the last one has passed to the output register.
// The store needs no clearing pass after reset; only entries that hold text
// ever feed a result or a write-back.
`default_nettype none

module cursor_line_editor_buffer #(
	parameter int STORE_DEPTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  req_type,
	input  wire logic [7:0]  char_in,
	input  wire logic [9:0]  read_index,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       char_out,
	output logic [10:0]      text_length,
	output logic [10:0]      cursor_pos,
	output logic [1:0]       status
);

	localparam int ADDR_W = $clog2(STORE_DEPTH);

	logic                res_valid;
	logic                res_ready;
	clebuf_pkg::result_t res;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [7:0]          ram_wdata;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [7:0]          ram_rdata;

	// request sequencer
	clebuf_ctrl #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.char_in   (char_in),
		.read_index(read_index),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// text store
	clebuf_ram #(
		.WIDTH(clebuf_pkg::CHAR_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// result register
	clebuf_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.char_out   (char_out),
		.text_length(text_length),
		.cursor_pos (cursor_pos),
		.status     (status)
	);

endmodule

`default_nettype wire

FILE: tb/sv/clebuf_checker.sv
// ----------------------------------------------------------------------------
// clebuf_checker
// Watches both channels of the gap buffer line editor. It keeps its own copy
// of the line (left part, right part, store) and works out the result of
// every accepted request, then compares each returned result field by field
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module clebuf_checker
	import clebuf_pkg::*;
#(
	parameter int STORE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [2:0]         req_type,
	input  logic [CHAR_W-1:0]  char_in,
	input  logic [INDEX_W-1:0] read_index,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [CHAR_W-1:0]  char_out,
	input  logic [COUNT_W-1:0] text_length,
	input  logic [COUNT_W-1:0] cursor_pos,
	input  logic [1:0]         status,
	output int                 fail_count,
	output int                 pending
);

	// line copy: left text at the bottom, right text at the top of the store
	logic [CHAR_W-1:0] line_text [STORE_DEPTH];
	int left_len;
	int right_len;
	result_t expected_q [$];

	// apply one edit request to the line copy and return its result
	function automatic result_t edit_line(input logic [2:0] code,
			input logic [CHAR_W-1:0] ch, input logic [INDEX_W-1:0] idx);
		result_t res;
		int len;
		res = '0;
		res.status = ST_DONE;
		len = left_len + right_len;
		case (code)
		REQ_INSERT: begin
			if (len >= STORE_DEPTH) begin
				res.status = ST_FULL;
			end else begin
				line_text[left_len] = ch;
				left_len++;
			end
		end
		REQ_LEFT: begin
			if (left_len == 0) begin
				res.status = ST_BOUNDARY;
			end else begin
				line_text[STORE_DEPTH - right_len - 1] = line_text[left_len - 1];
				left_len--;
				right_len++;
			end
		end
		REQ_RIGHT: begin
			if (right_len == 0) begin
				res.status = ST_BOUNDARY;
			end else begin
				line_text[left_len] = line_text[STORE_DEPTH - right_len];
				left_len++;
				right_len--;
			end
		end
		REQ_BACKSPACE: begin
			if (left_len == 0)
				res.status = ST_BOUNDARY;
			else
				left_len--;
		end
		REQ_READ: begin
			if (int'(idx) >= len)
				res.status = ST_BEYOND;
			else if (int'(idx) < left_len)
				res.char_out = line_text[idx];
			else
				res.char_out = line_text[STORE_DEPTH - len + int'(idx)];
		end
		default: res.status = ST_BOUNDARY;
		endcase
		res.text_length = COUNT_W'(left_len + right_len);
		res.cursor_pos = COUNT_W'(left_len);
		return res;
	endfunction

	// compare returned items first, then record the newly accepted request
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			left_len = 0;
			right_len = 0;
			expected_q.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$error("result item with no request outstanding");
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (char_out !== want.char_out) begin
						$error("char_out: expected %0d, actual %0d", want.char_out, char_out);
						fail_count++;
					end
					if (text_length !== want.text_length) begin
						$error("text_length: expected %0d, actual %0d",
							want.text_length, text_length);
						fail_count++;
					end
					if (cursor_pos !== want.cursor_pos) begin
						$error("cursor_pos: expected %0d, actual %0d",
							want.cursor_pos, cursor_pos);
						fail_count++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_q = {expected_q, edit_line(req_type, char_in, read_index)};
		end
		pending = expected_q.size();
	end

endmodule

FILE: tb/sv/cursor_line_editor_buffer_tb.sv
// ----------------------------------------------------------------------------
// cursor_line_editor_buffer_tb
// Drives edit requests into the gap buffer line editor: a directed pass over
// boundaries, unknown codes and reads past the text, a fill of the whole
// store with inserts into the full line, then random edit phases under
// different sender and receiver idling, one with a long output hold-off.
// ----------------------------------------------------------------------------

module cursor_line_editor_buffer_tb;
	import clebuf_pkg::*;

	localparam int DEPTH = 1024;
	localparam int REQ_CODES = 1 << 3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] req_type = '0;
	logic [CHAR_W-1:0] char_in = '0;
	logic [INDEX_W-1:0] read_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CHAR_W-1:0] char_out;
	logic [COUNT_W-1:0] text_length;
	logic [COUNT_W-1:0] cursor_pos;
	logic [1:0] status;

	int fail_count;
	int pending;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_count = 0;
	int hold_go = 0;
	int hold_seen = 0;
	// rough line shape, used only to steer the stimulus
	int left_chars = 0;
	int right_chars = 0;

	cursor_line_editor_buffer #(.STORE_DEPTH(DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .char_in(char_in), .read_index(read_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.char_out(char_out), .text_length(text_length),
		.cursor_pos(cursor_pos), .status(status)
	);

	clebuf_checker #(.STORE_DEPTH(DEPTH)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .char_in(char_in), .read_index(read_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.char_out(char_out), .text_length(text_length),
		.cursor_pos(cursor_pos), .status(status),
		.fail_count(fail_count), .pending(pending)
	);

	always #4 clk = ~clk;

	// receiver: random stall, or a long hold-off when one is requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_count <= 0;
		end else if (hold_count > 0) begin
			out_stall <= 1'b1;
			hold_count <= hold_count - 1;
		end else if (hold_go != hold_seen) begin
			out_stall <= 1'b1;
			hold_count <= 300;
			hold_seen <= hold_go;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// offer one item after a random gap and hold it until taken
	task automatic send_edit(input logic [2:0] code, input logic [CHAR_W-1:0] ch,
			input logic [INDEX_W-1:0] idx);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= code;
		char_in <= ch;
		read_index <= idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		case (code)
		REQ_INSERT: if (left_chars + right_chars < DEPTH) left_chars++;
		REQ_LEFT: begin
			if (left_chars > 0) begin
				left_chars--;
				right_chars++;
			end
		end
		REQ_RIGHT: begin
			if (right_chars > 0) begin
				right_chars--;
				left_chars++;
			end
		end
		REQ_BACKSPACE: if (left_chars > 0) left_chars--;
		default: ;
		endcase
	endtask

	// one random request; reads mostly land inside the text
	task automatic random_edit(input int insert_pct);
		int pick;
		int len;
		logic [2:0] code;
		logic [INDEX_W-1:0] idx;
		len = left_chars + right_chars;
		idx = INDEX_W'($urandom);
		if ($urandom_range(0, 99) < insert_pct) begin
			code = REQ_INSERT;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 20)
				code = REQ_LEFT;
			else if (pick < 40)
				code = REQ_RIGHT;
			else if (pick < 55)
				code = REQ_BACKSPACE;
			else if (pick < 95)
				code = REQ_READ;
			else
				code = 3'($urandom_range(int'(REQ_READ) + 1, REQ_CODES - 1));
			if (code == REQ_READ && len > 0 && $urandom_range(0, 3) != 0)
				idx = INDEX_W'($urandom_range(0, len - 1));
		end
		send_edit(code, CHAR_W'($urandom), idx);
	endtask

	task automatic run_phase(input int idle, input int stall, input int count,
			input int insert_pct);
		send_idle_pct = idle;
		stall_pct = stall;
		repeat (count)
			random_edit(insert_pct);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty line: every boundary, reads past the text, unknown codes
		send_edit(REQ_LEFT, '0, '0);
		send_edit(REQ_RIGHT, '0, '0);
		send_edit(REQ_BACKSPACE, '0, '0);
		send_edit(REQ_READ, '0, '0);
		send_edit(REQ_READ, '0, '1);
		for (int c = int'(REQ_READ) + 1; c < REQ_CODES; c++)
			send_edit(3'(c), '1, '1);

		// short text with extreme bytes, then reads on both sides of the gap
		send_edit(REQ_INSERT, '0, '0);
		send_edit(REQ_INSERT, '1, '0);
		send_edit(REQ_INSERT, "L", '0);
		send_edit(REQ_INSERT, "D", '0);
		send_edit(REQ_INSERT, "B", '0);
		send_edit(REQ_INSERT, "P", '0);
		send_edit(REQ_READ, '0, 10'd0);
		send_edit(REQ_READ, '0, 10'd5);
		send_edit(REQ_READ, '0, 10'd6);
		send_edit(REQ_LEFT, '0, '0);
		send_edit(REQ_LEFT, '0, '0);
		send_edit(REQ_READ, '0, 10'd4);
		send_edit(REQ_RIGHT, '0, '0);
		send_edit(REQ_BACKSPACE, '0, '0);
		send_edit(REQ_INSERT, 8'hA5, '0);
		send_edit(REQ_READ, '0, 10'd5);
		send_edit(REQ_RIGHT, '0, '0);
		send_edit(REQ_RIGHT, '0, '0);

		// fill the whole store, then insert into the full line
		send_idle_pct = 17;
		stall_pct = 17;
		while (left_chars + right_chars < DEPTH)
			random_edit(90);
		send_edit(REQ_INSERT, 8'h5A, '0);
		send_edit(REQ_LEFT, '0, '0);
		send_edit(REQ_INSERT, 8'hC3, '0);
		send_edit(REQ_READ, '0, '1);
		send_edit(REQ_READ, '0, '0);

		// random phases under each idling pattern
		run_phase(0, 0, 120, 30);
		run_phase(52, 0, 120, 15);
		hold_go++;
		run_phase(0, 52, 140, 30);
		run_phase(17, 17, 120, 10);
		in_valid <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (16) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// run limit
	initial begin
		#(8 * 500000);
		$display("FAILURE");
		$finish;
	end

endmodule
